### rtl/smdu_pkg.sv
// Shared types, constants and helper functions for the multiply/divide unit.
`default_nettype none

package smdu_pkg;

    // Instruction word bit positions
    localparam int IMM_BIT  = 13;
    localparam int SIGN_BIT = 19;
    localparam int DIV_BIT  = 21;
    localparam int CC_BIT   = 23;

    // Number of one-bit divide stages
    localparam int DIV_STEPS = 32;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_UNIMP   = 2'd1,
        ST_DIVZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic [31:0] instr;
        logic [31:0] rs1_value;
        logic [31:0] rs2_value;
        logic [31:0] y_in;
        logic [31:0] pc_in;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  rd_index;
        logic        rd_write;
        logic [31:0] rd_value;
        logic        y_write;
        logic [31:0] y_out;
        logic        icc_write;
        logic [3:0]  icc;
        logic [31:0] next_pc;
        logic [31:0] next_npc;
    } out_t;

    // Classified operation, front to back
    typedef struct packed {
        logic [4:0]  rd_index;
        status_t     status;
        logic        is_div;
        logic        is_signed;
        logic        set_cc;
        logic        neg;
        logic [31:0] op_a;
        logic [31:0] op_b;
        logic [31:0] pc;
    } op_t;

    // One stage of the back pipeline
    typedef struct packed {
        logic [4:0]  rd_index;
        status_t     status;
        logic        is_div;
        logic        is_signed;
        logic        set_cc;
        logic        neg;
        logic [31:0] pc;
        logic [31:0] rem;
        logic [31:0] dvd;
        logic [31:0] dvs;
        logic [63:0] prod;
    } pipe_t;

    // One restoring division step; quotient bits shift into dvd
    function automatic pipe_t div_step(pipe_t p);
        logic [32:0] t;
        logic [32:0] d;
        logic        qb;
        pipe_t       r;
        t  = {p.rem, p.dvd[31]};
        d  = {1'b0, p.dvs};
        qb = (t >= d);
        r  = p;
        r.rem = qb ? 32'(t - d) : t[31:0];
        r.dvd = {p.dvd[30:0], qb};
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/smdu_queue.sv
// Small FIFO of classified operations between front and back.
`default_nettype none

module smdu_queue #(
    parameter int DEPTH = smdu_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  smdu_pkg::op_t        wr_data,
    output logic                 full,
    input  wire logic            rd_en,
    output smdu_pkg::op_t        rd_data,
    output logic                 empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    smdu_pkg::op_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### rtl/smdu_front.sv
// Front end: decodes and classifies instructions into the operation queue.
`default_nettype none

module smdu_front #(
    parameter int DEPTH = smdu_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  smdu_pkg::in_t     in_item,
    output logic              full,
    input  wire logic         op_pop,
    output smdu_pkg::op_t     op_head,
    output logic              op_empty
);

    smdu_pkg::op_t op;
    logic [31:0]   b;
    logic [31:0]   want_y;
    logic          sgn;
    logic          q_full;

    // Operand selection and classification
    always_comb
    begin
        sgn = in_item.instr[smdu_pkg::SIGN_BIT];
        if (in_item.instr[smdu_pkg::IMM_BIT])
        begin
            b = {{19{in_item.instr[12]}}, in_item.instr[12:0]};
        end
        else
        begin
            b = in_item.rs2_value;
        end
        want_y = (sgn && in_item.rs1_value[31]) ? '1 : '0;

        op.rd_index  = in_item.instr[29:25];
        op.is_div    = in_item.instr[smdu_pkg::DIV_BIT];
        op.is_signed = sgn;
        op.set_cc    = in_item.instr[smdu_pkg::CC_BIT];
        op.neg       = sgn && (in_item.rs1_value[31] ^ b[31]);
        op.pc        = in_item.pc_in;
        op.status    = smdu_pkg::ST_DONE;
        op.op_a      = in_item.rs1_value;
        op.op_b      = b;
        if (op.is_div)
        begin
            if (in_item.y_in != want_y)
            begin
                op.status = smdu_pkg::ST_UNIMP;
            end
            else if (b == '0)
            begin
                op.status = smdu_pkg::ST_DIVZERO;
            end
            // signed divide works on magnitudes
            if (sgn && in_item.rs1_value[31])
            begin
                op.op_a = 32'(0) - in_item.rs1_value;
            end
            if (sgn && b[31])
            begin
                op.op_b = 32'(0) - b;
            end
        end
    end

    assign full = q_full;

    smdu_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !q_full),
        .wr_data (op),
        .full    (q_full),
        .rd_en   (op_pop),
        .rd_data (op_head),
        .empty   (op_empty)
    );

endmodule

`default_nettype wire

### rtl/smdu_back.sv
// Back end: multiplier, bit-per-stage divide pipeline and result register.
`default_nettype none

module smdu_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  smdu_pkg::op_t     op_head,
    input  wire logic         op_empty,
    output logic              op_pop,
    output logic              empty,
    input  wire logic         pop,
    output smdu_pkg::out_t    out_item
);

    localparam int NS = smdu_pkg::DIV_STEPS;

    smdu_pkg::pipe_t s_reg [NS+1];
    logic [NS:0]     v_reg;
    smdu_pkg::pipe_t s0_next;
    smdu_pkg::out_t  out_reg, out_next;
    logic            out_valid_reg;
    logic            advance;
    logic [65:0]     prod_full;
    logic [31:0]     q;
    logic [31:0]     res;
    smdu_pkg::pipe_t last;

    assign advance = !out_valid_reg || pop;
    assign op_pop  = advance && !op_empty;
    assign empty   = !out_valid_reg;
    assign out_item = out_reg;

    // Stage zero load: product and divide setup
    always_comb
    begin
        prod_full = 66'($signed({op_head.is_signed & op_head.op_a[31], op_head.op_a})
                      * $signed({op_head.is_signed & op_head.op_b[31], op_head.op_b}));
        s0_next.rd_index  = op_head.rd_index;
        s0_next.status    = op_head.status;
        s0_next.is_div    = op_head.is_div;
        s0_next.is_signed = op_head.is_signed;
        s0_next.set_cc    = op_head.set_cc;
        s0_next.neg       = op_head.neg;
        s0_next.pc        = op_head.pc;
        s0_next.rem       = '0;
        s0_next.dvd       = op_head.op_a;
        s0_next.dvs       = op_head.op_b;
        s0_next.prod      = prod_full[63:0];
    end

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_reg         <= {v_reg[NS-1:0], !op_empty};
            out_valid_reg <= v_reg[NS];
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s_reg[0] <= s0_next;
            for (int i = 1; i <= NS; i++)
            begin
                s_reg[i] <= smdu_pkg::div_step(s_reg[i-1]);
            end
            out_reg <= out_next;
        end
    end

    // Result formatting
    always_comb
    begin
        last = s_reg[NS];
        q    = last.dvd;
        if (!last.is_div)
        begin
            res = last.prod[31:0];
        end
        else if (last.is_signed && last.neg)
        begin
            res = 32'(0) - q;
        end
        else if (last.is_signed && q[31])
        begin
            res = 32'h7FFF_FFFF;
        end
        else
        begin
            res = q;
        end

        out_next          = '0;
        out_next.status   = last.status;
        out_next.rd_index = last.rd_index;
        if (last.status == smdu_pkg::ST_DONE)
        begin
            out_next.rd_write = 1'b1;
            out_next.rd_value = res;
            if (!last.is_div)
            begin
                out_next.y_write = 1'b1;
                out_next.y_out   = last.prod[63:32];
            end
            if (last.set_cc)
            begin
                out_next.icc_write = 1'b1;
                out_next.icc       = {res[31], (res == '0), 2'b00};
            end
            out_next.next_pc  = last.pc + 32'd4;
            out_next.next_npc = last.pc + 32'd8;
        end
    end

endmodule

`default_nettype wire

### rtl/sparc_muldiv_emulation_unit.sv
// A pushed instruction passes the queue, stage-zero load, 32 divide stages and result register.
// Throughput: one instruction per cycle unless stalled; the one-bit divide stages set latency.
// The pipeline stalls as a whole while the result register holds an untaken result.
// Reset (rst_n low, asynchronous) empties the queue and clears all pipeline valids.
// Top level: SPARC V8 multiply/divide unit with queue-style ports.
`default_nettype none

module sparc_muldiv_emulation_unit #(
    parameter int QUEUE_DEPTH = smdu_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  smdu_pkg::in_t     in_item,
    output logic              full,
    output logic              empty,
    input  wire logic         pop,
    output smdu_pkg::out_t    out_item
);

    smdu_pkg::op_t op_head;
    logic          op_empty;
    logic          op_pop;

    smdu_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_item  (in_item),
        .full     (full),
        .op_pop   (op_pop),
        .op_head  (op_head),
        .op_empty (op_empty)
    );

    smdu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_head  (op_head),
        .op_empty (op_empty),
        .op_pop   (op_pop),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    // Failed instructions write nothing back
    a_fail_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.status != smdu_pkg::ST_DONE
            |-> !out_item.rd_write && !out_item.y_write && !out_item.icc_write)
        else $error("failed instruction requests a write");

    // Completed instructions advance PC and NPC consistently
    a_npc: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.status == smdu_pkg::ST_DONE
            |-> out_item.next_npc == out_item.next_pc + 32'd4)
        else $error("next_npc does not follow next_pc");

    // V and C are always cleared
    a_icc_vc: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.icc_write |-> out_item.icc[1:0] == 2'b00)
        else $error("V or C set in condition codes");

endmodule

`default_nettype wire

### verif/smdu_checker.sv
// Checker: watches both channels, predicts each result and compares it as a whole.
`timescale 1ns / 1ps

module smdu_checker
    import smdu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire logic full,
    input  in_t       in_item,
    input  wire logic empty,
    input  wire logic pop,
    input  out_t      out_item,
    output int        errors,
    output int        pending
);

    out_t expected_q[$];

    // Compute the architectural result of one instruction
    function automatic out_t execute_instr(in_t it);
        out_t        r;
        logic [31:0] b;
        logic [31:0] want;
        logic [31:0] res;
        logic [31:0] hi;
        logic [31:0] abs_a;
        logic [31:0] abs_b;
        logic [31:0] q;
        logic [63:0] p;
        logic        is_div;
        logic        is_sgn;
        logic        is_cc;
        logic        neg;
        status_t     st;
        r      = '0;
        res    = '0;
        hi     = '0;
        st     = ST_DONE;
        is_div = it.instr[DIV_BIT];
        is_sgn = it.instr[SIGN_BIT];
        is_cc  = it.instr[CC_BIT];
        b = it.instr[IMM_BIT] ? {{19{it.instr[12]}}, it.instr[12:0]} : it.rs2_value;
        if (is_div)
        begin
            want = (is_sgn && it.rs1_value[31]) ? 32'hFFFF_FFFF : 32'h0;
            if (it.y_in != want)
                st = ST_UNIMP;
            else if (b == 0)
                st = ST_DIVZERO;
            else if (is_sgn)
            begin
                abs_a = it.rs1_value[31] ? -it.rs1_value : it.rs1_value;
                abs_b = b[31] ? -b : b;
                q     = abs_a / abs_b;
                neg   = it.rs1_value[31] ^ b[31];
                if (neg)
                    res = -q;
                else
                    res = (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
            end
            else
                res = it.rs1_value / b;
        end
        else
        begin
            if (is_sgn)
                p = $signed({{32{it.rs1_value[31]}}, it.rs1_value})
                    * $signed({{32{b[31]}}, b});
            else
                p = {32'h0, it.rs1_value} * {32'h0, b};
            res = p[31:0];
            hi  = p[63:32];
        end
        r.status   = st;
        r.rd_index = it.instr[29:25];
        if (st == ST_DONE)
        begin
            r.rd_write = 1'b1;
            r.rd_value = res;
            if (!is_div)
            begin
                r.y_write = 1'b1;
                r.y_out   = hi;
            end
            if (is_cc)
            begin
                r.icc_write = 1'b1;
                r.icc       = {res[31], res == 0, 2'b00};
            end
            r.next_pc  = it.pc_in + 32'd4;
            r.next_npc = it.pc_in + 32'd8;
        end
        return r;
    endfunction

    // Predict on input transfer, compare on result transfer
    always @(posedge clk or negedge rst_n)
    begin
        out_t e;
        if (!rst_n)
        begin
            errors  <= 0;
            pending <= 0;
            expected_q.delete();
        end
        else
        begin
            if (push && !full)
                expected_q.push_back(execute_instr(in_item));
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("ERROR: unexpected result %h", out_item);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (out_item !== e)
                    begin
                        if (errors < 10)
                        begin
                            $display("ERROR: result mismatch");
                            $display("  status   exp %0d act %0d", e.status, out_item.status);
                            $display("  rd_index exp %0d act %0d", e.rd_index,
                                     out_item.rd_index);
                            $display("  rd_write exp %0d act %0d", e.rd_write,
                                     out_item.rd_write);
                            $display("  rd_value exp %h act %h", e.rd_value, out_item.rd_value);
                            $display("  y_write  exp %0d act %0d", e.y_write, out_item.y_write);
                            $display("  y_out    exp %h act %h", e.y_out, out_item.y_out);
                            $display("  icc_wr   exp %0d act %0d", e.icc_write,
                                     out_item.icc_write);
                            $display("  icc      exp %h act %h", e.icc, out_item.icc);
                            $display("  next_pc  exp %h act %h", e.next_pc, out_item.next_pc);
                            $display("  next_npc exp %h act %h", e.next_npc,
                                     out_item.next_npc);
                        end
                        errors <= errors + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

### verif/tb_top.sv
// Testbench top: clock, reset, instruction stimulus, result draining and verdict.
`timescale 1ns / 1ps

module tb_top;
    import smdu_pkg::*;

    localparam int LATENCY   = 34;
    localparam int MAX_CYCLE = 400000;

    logic clk;
    logic rst_n;
    logic push;
    logic pop;
    logic full;
    logic empty;
    in_t  in_item;
    out_t out_item;
    int   errors;
    int   pending;
    int   cycle;
    int   send_idle;
    int   recv_idle;
    int   hold_recv;

    sparc_muldiv_emulation_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_item  (in_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    smdu_checker u_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Timeout guard
    initial
    begin
        cycle = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle > MAX_CYCLE)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver: random stalls plus a long hold-off on request
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_recv > 0)
            begin
                pop <= 1'b0;
                hold_recv--;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Random operand with a bias toward edge values
    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // Random instruction; divides mostly with an acceptable Y
    function automatic in_t random_instr();
        in_t it;
        it.instr     = $urandom;
        it.rs1_value = pick_value();
        it.rs2_value = pick_value();
        if ($urandom_range(3) == 0)
            it.instr[12:0] = $urandom_range(1) ? 13'h1FFF : 13'h1000;
        if ($urandom_range(9) == 0)
            it.y_in = $urandom;
        else if (it.instr[SIGN_BIT] && it.rs1_value[31])
            it.y_in = 32'hFFFF_FFFF;
        else
            it.y_in = 32'h0;
        it.pc_in = $urandom_range(3) == 0 ? 32'hFFFF_FFFC : $urandom;
        return it;
    endfunction

    // Offer one instruction and wait for its transfer
    task automatic send_instr(in_t it);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic build_instr(output in_t it, input logic dv, input logic sg, input logic cc,
                               input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] y);
        it           = '0;
        it.instr     = $urandom;
        it.instr[IMM_BIT]  = 1'b0;
        it.instr[DIV_BIT]  = dv;
        it.instr[SIGN_BIT] = sg;
        it.instr[CC_BIT]   = cc;
        it.rs1_value = a;
        it.rs2_value = b;
        it.y_in      = y;
        it.pc_in     = $urandom;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        in_t it;
        int  k;
        rst_n     = 1'b0;
        push      = 1'b0;
        in_item   = '0;
        hold_recv = 0;
        send_idle = 0;
        recv_idle = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each operation, extremes and special cases
        for (k = 0; k < 8; k++)
        begin
            build_instr(it, k[0], k[1], k[2], 32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
            if (k[0] && k[1])
                it.y_in = 32'hFFFF_FFFF;
            send_instr(it);
        end
        build_instr(it, 1, 1, 1, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_instr(it);   // signed overflow saturates
        build_instr(it, 1, 0, 1, 32'd5, 32'd0, 32'h0);
        send_instr(it);   // zero divisor
        build_instr(it, 1, 0, 0, 32'd5, 32'd1, 32'd1);
        send_instr(it);   // unsigned divide, Y not zero
        build_instr(it, 1, 1, 0, 32'd5, 32'd1, 32'hFFFF_FFFF);
        send_instr(it);   // signed divide, Y not sign extension
        build_instr(it, 0, 1, 1, 32'h0, 32'h1234, 32'h0);
        send_instr(it);   // zero product sets Z
        build_instr(it, 1, 1, 1, 32'd7, 32'h0, 32'h0);
        it.instr[IMM_BIT] = 1'b1;
        it.instr[12:0]    = 13'h1FFF;
        send_instr(it);   // immediate minus one
        it.instr[12:0] = 13'h0FFF;
        send_instr(it);
        build_instr(it, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        it.instr = 32'hFFFF_FFFF;
        it.pc_in = 32'hFFFF_FFFC;
        send_instr(it);

        // Receiver holds off while the sender keeps offering
        hold_recv = 200;
        for (k = 0; k < 60; k++)
            send_instr(random_instr());
        drain();

        // Random phases with different idle mixes
        send_idle = 27; recv_idle = 51;
        for (k = 0; k < 230; k++)
            send_instr(random_instr());
        drain();
        send_idle = 51; recv_idle = 27;
        for (k = 0; k < 230; k++)
            send_instr(random_instr());
        send_idle = 0; recv_idle = 0;
        for (k = 0; k < 230; k++)
            send_instr(random_instr());
        drain();

        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
rtl/smdu_pkg.sv
rtl/smdu_queue.sv
rtl/smdu_front.sv
rtl/smdu_back.sv
rtl/sparc_muldiv_emulation_unit.sv
verif/smdu_checker.sv
verif/tb_top.sv
